[hdl/rbr_pkg.sv]
// ----------------------------------------------------------------------------
// rbr_pkg: shared types and constants
// Opcodes, configuration register indexes and coder constants for the byte-renormalizing
// range encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rbr_pkg;

  // opcodes
  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_ENC_TOTAL = 2'd1,
    OP_ENC_SHIFT = 2'd2,
    OP_FINISH    = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic CFG_FIRST_BYTE    = 1'b0;
  localparam logic CFG_HEADER_LENGTH = 1'b1;

  // coder constants
  localparam logic [31:0] TOP_VAL     = 32'h8000_0000;
  localparam logic [31:0] BOT_VAL     = 32'h0080_0000;
  localparam logic [31:0] LOW_LIMIT   = 32'h7F80_0000;
  localparam logic [5:0]  PENDING_MAX = 6'd56;
  localparam logic [1:0]  RENORM_STEPS = 2'd3;
  localparam logic [31:0] FINISH_ADD  = 32'd5;

endpackage

`default_nettype wire

[hdl/rbr_in_if.sv]
// ----------------------------------------------------------------------------
// rbr_in_if: input word channel
// Valid/ready channel carrying one encoder command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [16:0] sym_freq;
  logic [15:0] cum_freq;
  logic [16:0] total_freq;
  logic [4:0]  shift_amount;

  modport source (output valid, opcode, sym_freq, cum_freq, total_freq, shift_amount,
                  input ready);
  modport sink   (input valid, opcode, sym_freq, cum_freq, total_freq, shift_amount,
                  output ready);
endinterface

`default_nettype wire

[hdl/rbr_out_if.sv]
// ----------------------------------------------------------------------------
// rbr_out_if: result word channel
// Valid/ready channel carrying one coded byte with its status.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic [31:0] total_bytes;
  logic        pending_overflow;

  modport source (output valid, out_byte, last_byte, total_bytes, pending_overflow,
                  input ready);
  modport sink   (input valid, out_byte, last_byte, total_bytes, pending_overflow,
                  output ready);
endinterface

`default_nettype wire

[hdl/range_encoder_byte_renorm_core.sv]
// ----------------------------------------------------------------------------
// range_encoder_byte_renorm_core: 32-bit range encoder
// Byte-wise renormalizing range encoder with carry through pending bytes.
// ----------------------------------------------------------------------------
// One command word at a time. A start gives no bytes. An encode takes its
// renormalization steps (at most three), giving each emitted byte and
// any pending bytes behind it, then for a divide-by-total encode runs the
// bit-serial divider, and then the shared 32x17 multiplier and the interval
// update. A finish takes its renormalization steps, settles the final byte
// and gives the carry byte, any pending bytes, the final byte and three
// count bytes. Each emitted byte waits in a one-byte lookahead so the last
// byte of a command can be flagged; the output register lets the next
// command start while the final byte is still waiting to be taken.
`default_nettype none

module range_encoder_byte_renorm_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rbr_in_if.sink     in_ch,
  rbr_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_RENORM = 11'b000_0000_0010,
    S_FILL   = 11'b000_0000_0100,
    S_DIV    = 11'b000_0000_1000,
    S_MULT   = 11'b000_0001_0000,
    S_MULS   = 11'b000_0010_0000,
    S_UPD    = 11'b000_0100_0000,
    S_FIN    = 11'b000_1000_0000,
    S_FLEAD  = 11'b001_0000_0000,
    S_TAIL   = 11'b010_0000_0000,
    S_END    = 11'b100_0000_0000
  } state_t;

  state_t      state_r, state_nxt;

  // configuration
  logic [7:0]  first_byte_r;
  logic [31:0] header_len_r;

  // coder state
  logic [31:0] low_r, low_nxt;
  logic [31:0] range_r, range_nxt;
  logic [7:0]  carry_r, carry_nxt;
  logic [5:0]  pend_r, pend_nxt;
  logic [31:0] bc_r, bc_nxt;
  logic        ovf_r, ovf_nxt;

  // latched command word
  rbr_pkg::op_t op_r;
  logic [16:0] sym_r;
  logic [15:0] cum_r;
  logic [16:0] tot_r;
  logic [4:0]  sh_r;

  // sequencer working registers
  logic [1:0]  steps_r, steps_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic        tail_r, tail_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [9:0]  fb_r, fb_nxt;
  logic [31:0] r_r, r_nxt;
  logic [31:0] t_r, rs_r;

  // lookahead byte and output register
  logic [7:0]  hold_r, hold_nxt;
  logic        hold_v_r, hold_v_nxt;
  logic        out_v_r, out_v_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic [31:0] out_tot_r, out_tot_nxt;
  logic        out_ovf_r, out_ovf_nxt;

  logic        in_acc;
  logic        out_free;
  logic        can_emit;
  logic        emit_en;
  logic [7:0]  emit_byte;
  logic        push_final;

  logic        renorm_go, case_lo, case_hi;
  logic [31:0] bc_fin;
  logic [9:0]  fb_hi;
  logic        fb_below;
  logic [16:0] mul_b;
  logic [48:0] prod;
  logic [17:0] lt_sy;

  logic        div_start, div_busy, div_done;
  logic [31:0] div_q;

  rbr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (range_r),
    .divisor  ((tot_r == 17'd0) ? 17'd1 : tot_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_v_r || out_ch.ready;
  assign can_emit = !hold_v_r || out_free;

  // renormalization step classification
  assign renorm_go = (range_r <= rbr_pkg::BOT_VAL) && (steps_r < rbr_pkg::RENORM_STEPS);
  assign case_lo   = low_r < rbr_pkg::LOW_LIMIT;
  assign case_hi   = low_r[31];

  // final settled byte
  assign bc_fin   = bc_r + rbr_pkg::FINISH_ADD;
  assign fb_hi    = {1'b0, low_r[31:23]};
  assign fb_below = low_r[22:0] < bc_fin[23:1];

  // shared multiplier
  assign mul_b = (state_r == S_MULT) ? {1'b0, cum_r} : sym_r;
  assign prod  = r_r * mul_b;
  assign lt_sy = {2'b0, cum_r} + {1'b0, sym_r};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    range_nxt = range_r;
    carry_nxt = carry_r;
    pend_nxt  = pend_r;
    bc_nxt    = bc_r;
    ovf_nxt   = ovf_r;
    steps_nxt = steps_r;
    fill_nxt  = fill_r;
    tail_nxt  = tail_r;
    idx_nxt   = idx_r;
    fb_nxt    = fb_r;
    r_nxt     = r_r;
    emit_en   = 1'b0;
    emit_byte = carry_r;
    push_final = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          steps_nxt = '0;
          tail_nxt  = 1'b0;
          idx_nxt   = '0;
          if (rbr_pkg::op_t'(in_ch.opcode) == rbr_pkg::OP_START) begin
            low_nxt   = '0;
            range_nxt = rbr_pkg::TOP_VAL;
            carry_nxt = first_byte_r;
            pend_nxt  = '0;
            bc_nxt    = header_len_r;
            ovf_nxt   = 1'b0;
          end else begin
            state_nxt = S_RENORM;
          end
        end
      end
      S_RENORM: begin
        if (renorm_go) begin
          if (case_lo || case_hi) begin
            if (can_emit) begin
              emit_en   = 1'b1;
              emit_byte = case_lo ? carry_r : carry_r + 8'd1;
              fill_nxt  = case_lo ? 8'hFF : 8'h00;
              carry_nxt = low_r[30:23];
              range_nxt = {range_r[23:0], 8'h00};
              low_nxt   = {1'b0, low_r[22:0], 8'h00};
              bc_nxt    = bc_r + 32'd1;
              steps_nxt = steps_r + 2'd1;
              state_nxt = S_FILL;
            end
          end else begin
            if (pend_r < rbr_pkg::PENDING_MAX) pend_nxt = pend_r + 6'd1;
            else ovf_nxt = 1'b1;
            range_nxt = {range_r[23:0], 8'h00};
            low_nxt   = {1'b0, low_r[22:0], 8'h00};
            bc_nxt    = bc_r + 32'd1;
            steps_nxt = steps_r + 2'd1;
          end
        end else begin
          case (op_r)
            rbr_pkg::OP_ENC_TOTAL: begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
            rbr_pkg::OP_ENC_SHIFT: begin
              r_nxt     = range_r >> sh_r;
              state_nxt = S_MULT;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_FILL: begin
        if (pend_r == 6'd0) begin
          state_nxt = tail_r ? S_TAIL : S_RENORM;
        end else if (can_emit) begin
          emit_en   = 1'b1;
          emit_byte = fill_r;
          pend_nxt  = pend_r - 6'd1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          r_nxt     = div_q;
          state_nxt = S_MULT;
        end
      end
      S_MULT: state_nxt = S_MULS;
      S_MULS: state_nxt = S_UPD;
      S_UPD: begin
        low_nxt = low_r + t_r;
        if (op_r == rbr_pkg::OP_ENC_TOTAL) begin
          range_nxt = (lt_sy < {1'b0, tot_r}) ? rs_r : range_r - t_r;
        end else begin
          range_nxt = ((lt_sy >> sh_r) != 18'd0) ? range_r - t_r : rs_r;
        end
        state_nxt = S_END;
      end
      S_FIN: begin
        bc_nxt    = bc_fin;
        fb_nxt    = fb_below ? fb_hi : fb_hi + 10'd1;
        state_nxt = S_FLEAD;
      end
      S_FLEAD: begin
        if (can_emit) begin
          emit_en   = 1'b1;
          emit_byte = (fb_r > 10'd255) ? carry_r + 8'd1 : carry_r;
          fill_nxt  = (fb_r > 10'd255) ? 8'h00 : 8'hFF;
          tail_nxt  = 1'b1;
          state_nxt = S_FILL;
        end
      end
      S_TAIL: begin
        if (can_emit) begin
          emit_en = 1'b1;
          case (idx_r)
            2'd0:    emit_byte = fb_r[7:0];
            2'd1:    emit_byte = bc_r[23:16];
            2'd2:    emit_byte = bc_r[15:8];
            default: emit_byte = bc_r[7:0];
          endcase
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) state_nxt = S_END;
        end
      end
      S_END: begin
        if (!hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push_final = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // lookahead and output register
  always_comb begin
    hold_nxt     = hold_r;
    hold_v_nxt   = hold_v_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    out_tot_nxt  = out_tot_r;
    out_ovf_nxt  = out_ovf_r;
    if (emit_en) begin
      hold_nxt   = emit_byte;
      hold_v_nxt = 1'b1;
    end
    if ((emit_en && hold_v_r) || push_final) begin
      out_v_nxt    = 1'b1;
      out_byte_nxt = hold_r;
      out_last_nxt = push_final;
      out_tot_nxt  = (push_final && op_r == rbr_pkg::OP_FINISH) ? bc_r : 32'd0;
      out_ovf_nxt  = ovf_r;
    end
    if (push_final) hold_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      low_r        <= '0;
      range_r      <= rbr_pkg::TOP_VAL;
      carry_r      <= '0;
      pend_r       <= '0;
      bc_r         <= '0;
      ovf_r        <= 1'b0;
      first_byte_r <= '0;
      header_len_r <= '0;
      hold_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
      steps_r      <= '0;
      tail_r       <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r  <= state_nxt;
      low_r    <= low_nxt;
      range_r  <= range_nxt;
      carry_r  <= carry_nxt;
      pend_r   <= pend_nxt;
      bc_r     <= bc_nxt;
      ovf_r    <= ovf_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
      steps_r  <= steps_nxt;
      tail_r   <= tail_nxt;
      idx_r    <= idx_nxt;
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          rbr_pkg::CFG_FIRST_BYTE:    first_byte_r <= cfg_wdata[7:0];
          rbr_pkg::CFG_HEADER_LENGTH: header_len_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    // payload
    fill_r     <= fill_nxt;
    fb_r       <= fb_nxt;
    r_r        <= r_nxt;
    hold_r     <= hold_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_tot_r  <= out_tot_nxt;
    out_ovf_r  <= out_ovf_nxt;
    if (state_r == S_MULT) t_r  <= prod[31:0];
    if (state_r == S_MULS) rs_r <= prod[31:0];
    if (in_acc) begin
      op_r  <= rbr_pkg::op_t'(in_ch.opcode);
      sym_r <= in_ch.sym_freq;
      cum_r <= in_ch.cum_freq;
      tot_r <= in_ch.total_freq;
      sh_r  <= in_ch.shift_amount;
    end
  end

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_v_r;
  assign out_ch.out_byte         = out_byte_r;
  assign out_ch.last_byte        = out_last_r;
  assign out_ch.total_bytes      = out_tot_r;
  assign out_ch.pending_overflow = out_ovf_r;

  // no byte is left in the lookahead between commands
  a_hold_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hold_v_r)
    else $error("lookahead byte left behind in idle");

  // pending count never passes its cap
  a_pend_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= rbr_pkg::PENDING_MAX)
    else $error("pending count above cap");

  // divider only runs while the sequencer waits on it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == S_DIV)
    else $error("divider busy outside divide state");

endmodule

`default_nettype wire

[hdl/rbr_div.sv]
// ----------------------------------------------------------------------------
// rbr_div: iterative divider
// Restoring 32-by-17-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rbr_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [16:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [31:0]      quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] dsr_r, dsr_nxt;
  logic [17:0] rem_sh;
  logic [17:0] rem_sub;

  // trial subtract of the shifted remainder
  assign rem_sh  = {rem_r, q_r[31]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd31;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (!rem_sub[17]) begin
        rem_nxt = rem_sub[16:0];
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[16:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: range encoder byte renormalization check
// Drives command words into the range encoder, predicts every coded byte
// with an in-bench model of the coder state, and compares the byte stream
// word by word under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  typedef struct {
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [31:0] total_bytes;
    logic        pending_overflow;
  } coded_word_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  rbr_in_if  in_ch ();
  rbr_out_if out_ch ();

  range_encoder_byte_renorm_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // coder state mirror
  logic [31:0] enc_low;
  logic [31:0] enc_range;
  logic [7:0]  enc_carry;
  logic [5:0]  enc_pending;
  logic [31:0] enc_count;
  logic        enc_ovf;
  logic [7:0]  reg_first;
  logic [31:0] reg_header;

  coded_word_t coded_q[$];
  logic [7:0]  byte_stage[$];
  int          failures;
  int          words_sent;
  int          bytes_checked;
  bit          calm;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // release the carry byte and any pending bytes
  task automatic release_run(input logic [7:0] lead, input logic [7:0] fill);
    byte_stage.push_back(lead);
    while (enc_pending != 6'd0) begin
      byte_stage.push_back(fill);
      enc_pending--;
    end
  endtask

  task automatic renormalize();
    int steps;
    steps = 0;
    while (enc_range <= rbr_pkg::BOT_VAL && steps < 3) begin
      if (enc_low < rbr_pkg::LOW_LIMIT) begin
        release_run(enc_carry, 8'hff);
        enc_carry = enc_low[30:23];
      end else if (enc_low[31]) begin
        release_run(enc_carry + 8'd1, 8'h00);
        enc_carry = enc_low[30:23];
      end else if (enc_pending < rbr_pkg::PENDING_MAX) begin
        enc_pending++;
      end else begin
        enc_ovf = 1'b1;
      end
      enc_range = enc_range << 8;
      enc_low   = (enc_low << 8) & (rbr_pkg::TOP_VAL - 32'd1);
      enc_count++;
      steps++;
    end
  endtask

  // work out the coded bytes one command word causes
  task automatic predict_bytes(input logic [1:0] op, input logic [16:0] sy,
                               input logic [15:0] lt, input logic [16:0] tot,
                               input logic [4:0] sh);
    logic [31:0] r, t, sum, fb;
    coded_word_t w;
    bit fin;
    int n;
    byte_stage.delete();
    fin = 0;
    sum = {16'd0, lt} + {15'd0, sy};
    case (op)
      rbr_pkg::OP_START: begin
        enc_low = 32'd0;
        enc_range = rbr_pkg::TOP_VAL;
        enc_carry = reg_first;
        enc_pending = 6'd0;
        enc_count = reg_header;
        enc_ovf = 1'b0;
      end
      rbr_pkg::OP_ENC_TOTAL: begin
        renormalize();
        r = enc_range / ((tot == 17'd0) ? 32'd1 : {15'd0, tot});
        t = r * {16'd0, lt};
        enc_low = enc_low + t;
        enc_range = enc_range - t;
        if (sum < {15'd0, tot}) enc_range = r * {15'd0, sy};
      end
      rbr_pkg::OP_ENC_SHIFT: begin
        renormalize();
        r = enc_range >> sh;
        t = r * {16'd0, lt};
        enc_low = enc_low + t;
        if ((sum >> sh) != 32'd0) enc_range = enc_range - t;
        else enc_range = r * {15'd0, sy};
      end
      default: begin
        renormalize();
        enc_count = enc_count + rbr_pkg::FINISH_ADD;
        if ((enc_low & (rbr_pkg::BOT_VAL - 32'd1)) < ((enc_count & 32'h00ff_ffff) >> 1))
          fb = enc_low >> 23;
        else
          fb = (enc_low >> 23) + 32'd1;
        if (fb > 32'hff) release_run(enc_carry + 8'd1, 8'h00);
        else release_run(enc_carry, 8'hff);
        byte_stage.push_back(fb[7:0]);
        byte_stage.push_back(enc_count[23:16]);
        byte_stage.push_back(enc_count[15:8]);
        byte_stage.push_back(enc_count[7:0]);
        fin = 1;
      end
    endcase
    n = byte_stage.size();
    if (n > 64) n = 64;
    for (int k = 0; k < n; k++) begin
      w.out_byte = byte_stage[k];
      w.last_byte = (k == n - 1);
      w.total_bytes = (fin && k == n - 1) ? enc_count : 32'd0;
      w.pending_overflow = enc_ovf;
      coded_q.push_back(w);
    end
  endtask

  // send one command word; valid stays high across back-to-back words
  task automatic send_word(input logic [1:0] op, input logic [16:0] sy,
                           input logic [15:0] lt, input logic [16:0] tot,
                           input logic [4:0] sh);
    int gap;
    gap = (!calm && $urandom_range(99) < 29) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.sym_freq     <= sy;
    in_ch.cum_freq     <= lt;
    in_ch.total_freq   <= tot;
    in_ch.shift_amount <= sh;
    do @(posedge clk); while (!in_ch.ready);
    predict_bytes(op, sy, lt, tot, sh);
    words_sent++;
  endtask

  // drain, let the core settle, then write both registers
  task automatic drain_and_configure(input logic [7:0] fb, input logic [31:0] hdr);
    in_ch.valid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= rbr_pkg::CFG_FIRST_BYTE;
    cfg_wdata <= {24'd0, fb};
    @(posedge clk);
    cfg_index <= rbr_pkg::CFG_HEADER_LENGTH;
    cfg_wdata <= hdr;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_first  = fb;
    reg_header = hdr;
  endtask

  // result checker and random ready
  always @(posedge clk) begin
    coded_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (coded_q.size() == 0) begin
        $error("unexpected coded word %h", out_ch.out_byte);
        failures++;
      end else begin
        w = coded_q.pop_front();
        bytes_checked++;
        if (out_ch.out_byte !== w.out_byte) begin
          $error("out_byte expected %h actual %h", w.out_byte, out_ch.out_byte);
          failures++;
        end
        if (out_ch.last_byte !== w.last_byte) begin
          $error("last_byte expected %b actual %b", w.last_byte, out_ch.last_byte);
          failures++;
        end
        if (out_ch.total_bytes !== w.total_bytes) begin
          $error("total_bytes expected %h actual %h", w.total_bytes, out_ch.total_bytes);
          failures++;
        end
        if (out_ch.pending_overflow !== w.pending_overflow) begin
          $error("pending_overflow expected %b actual %b", w.pending_overflow,
                 out_ch.pending_overflow);
          failures++;
        end
      end
    end
    out_ch.ready <= calm || ($urandom_range(99) >= 29);
  end

  // encode and finish with no start: state straight out of reset
  task automatic test_encode_before_start();
    send_word(rbr_pkg::OP_ENC_TOTAL, 17'd3, 16'd1, 17'd7, 5'd0);
    send_word(rbr_pkg::OP_ENC_SHIFT, 17'd1, 16'd0, 17'd0, 5'd16);
    send_word(rbr_pkg::OP_FINISH, 17'd0, 16'd0, 17'd0, 5'd0);
  endtask

  // field extremes, zero total, out-of-range sizes
  task automatic test_field_extremes();
    drain_and_configure(8'hff, 32'hffff_ffff);
    send_word(rbr_pkg::OP_START, 17'd0, 16'd0, 17'd0, 5'd0);
    send_word(rbr_pkg::OP_ENC_TOTAL, 17'd1, 16'd0, 17'd65536, 5'd0);
    send_word(rbr_pkg::OP_ENC_TOTAL, 17'd1, 16'd65535, 17'd65536, 5'd0);
    send_word(rbr_pkg::OP_ENC_TOTAL, 17'd65536, 16'd0, 17'd65536, 5'd0);
    send_word(rbr_pkg::OP_ENC_TOTAL, 17'd5, 16'd2, 17'd0, 5'd0);
    send_word(rbr_pkg::OP_ENC_SHIFT, 17'd1, 16'd0, 17'd0, 5'd1);
    send_word(rbr_pkg::OP_ENC_SHIFT, 17'd1, 16'd65535, 17'd0, 5'd16);
    send_word(rbr_pkg::OP_ENC_SHIFT, 17'h1ffff, 16'hffff, 17'h1ffff, 5'd31);
    send_word(rbr_pkg::OP_ENC_SHIFT, 17'd9, 16'd3, 17'd0, 5'd0);
    send_word(rbr_pkg::OP_FINISH, 17'h1ffff, 16'hffff, 17'h1ffff, 5'h1f);
    send_word(rbr_pkg::OP_ENC_TOTAL, 17'd2, 16'd1, 17'd4, 5'd0);
    send_word(rbr_pkg::OP_FINISH, 17'd0, 16'd0, 17'd0, 5'd0);
  endtask

  // top symbol again and again keeps bytes pending until the count saturates
  task automatic test_pending_saturation();
    drain_and_configure(8'h00, 32'd0);
    send_word(rbr_pkg::OP_START, 17'd0, 16'd0, 17'd0, 5'd0);
    for (int i = 0; i < 30; i++)
      send_word(rbr_pkg::OP_ENC_SHIFT, 17'd1, 16'hffff, 17'd0, 5'd16);
    send_word(rbr_pkg::OP_FINISH, 17'd0, 16'd0, 17'd0, 5'd0);
    // start clears the sticky flag
    send_word(rbr_pkg::OP_START, 17'd0, 16'd0, 17'd0, 5'd0);
    send_word(rbr_pkg::OP_FINISH, 17'd0, 16'd0, 17'd0, 5'd0);
  endtask

  // one well-formed stream with random symbols, or a noise word
  task automatic random_stream(input int symbols);
    logic [16:0] tot, sy, lt;
    logic [4:0]  sh;
    send_word(rbr_pkg::OP_START, 17'($urandom), 16'($urandom), 17'($urandom),
              5'($urandom));
    for (int i = 0; i < symbols; i++) begin
      if ($urandom_range(99) < 8) begin
        send_word(2'($urandom_range(2, 1)), 17'($urandom), 16'($urandom),
                  17'($urandom), 5'($urandom));
      end else if ($urandom_range(1)) begin
        tot = 17'($urandom_range(65536, 1));
        lt  = 17'($urandom_range(tot - 17'd1, 0));
        sy  = 17'($urandom_range(tot - lt, 1));
        send_word(rbr_pkg::OP_ENC_TOTAL, sy, lt[15:0], tot, 5'($urandom));
      end else begin
        sh  = 5'($urandom_range(16, 1));
        tot = 17'd1 << sh;
        lt  = (sh > 5'd2 && $urandom_range(3) == 0) ? tot - 17'd1 :
              17'($urandom_range(tot - 17'd1, 0));
        sy  = 17'($urandom_range(tot - lt, 1));
        send_word(rbr_pkg::OP_ENC_SHIFT, sy, lt[15:0], 17'($urandom), sh);
      end
    end
    send_word(rbr_pkg::OP_FINISH, 17'($urandom), 16'($urandom), 17'($urandom),
              5'($urandom));
  endtask

  task automatic test_random_streams();
    int phase;
    phase = 0;
    while (words_sent < 200) begin
      if (phase % 3 == 0) begin
        case (phase / 3 % 3)
          0: drain_and_configure(8'h00, 32'hffff_fff0);
          1: drain_and_configure(8'($urandom), $urandom);
          default: drain_and_configure(8'hff, 32'd0);
        endcase
      end
      calm = (phase == 4);
      random_stream($urandom_range(24, 2));
      phase++;
    end
    calm = 0;
  endtask

  initial begin
    failures = 0;
    words_sent = 0;
    bytes_checked = 0;
    calm = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = rbr_pkg::CFG_FIRST_BYTE;
    cfg_wdata = 32'd0;
    in_ch.valid = 1'b0;
    in_ch.opcode = rbr_pkg::OP_START;
    in_ch.sym_freq = 17'd0;
    in_ch.cum_freq = 16'd0;
    in_ch.total_freq = 17'd0;
    in_ch.shift_amount = 5'd0;
    enc_low = 32'd0;
    enc_range = rbr_pkg::TOP_VAL;
    enc_carry = 8'd0;
    enc_pending = 6'd0;
    enc_count = 32'd0;
    enc_ovf = 1'b0;
    reg_first = 8'd0;
    reg_header = 32'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_encode_before_start();
    test_field_extremes();
    test_pending_saturation();
    test_random_streams();

    in_ch.valid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d command words and %0d coded bytes, with pending", words_sent,
             bytes_checked);
    $display("saturation, extremes and several register settings");
    if (failures == 0 && coded_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hdl/rbr_pkg.sv
hdl/rbr_in_if.sv
hdl/rbr_out_if.sv
hdl/rbr_div.sv
hdl/range_encoder_byte_renorm_core.sv
test/testbench.sv
